[rtl/i2cbm_pkg.sv]
// Shared types, codes and helpers for the I2C bit-level master.
// Used by i2cbm_regs, i2cbm_seq and i2c_bit_level_master_unit; no dependencies.
package i2cbm_pkg;

  localparam int DELAY_BITS = 8;
  localparam int CFG_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int CMP_W      = (DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;
  localparam logic [BIT_IDX_W-1:0]  BIT_LAST  = '1;

  localparam logic [CFG_W-1:0] LONG_DELAY_RST  = CFG_W'(4);
  localparam logic [CFG_W-1:0] BIT_DELAY_RST   = CFG_W'(2);
  localparam logic [CFG_W-1:0] SHORT_DELAY_RST = CFG_W'(1);
  localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = CFG_W'(250);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WA1, PH_WA2, PH_WAP,
    PH_WR_LOW, PH_WR_HIGH, PH_WR_TAIL, PH_RD_LOW, PH_RD_HIGH,
    PH_AK_LOW, PH_AK_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_WAIT_ACK = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_LONG_DELAY  = 2'd0,
    REG_BIT_DELAY   = 2'd1,
    REG_SHORT_DELAY = 2'd2,
    REG_ACK_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_delay;
    logic [CFG_W-1:0] bit_delay;
    logic [CFG_W-1:0] short_delay;
    logic [CFG_W-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [2:0]        op;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_driving;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_missing;
  } res_t;

  // Phase length: zero counts as one tick, clamp to counter range.
  function automatic logic [DELAY_BITS-1:0] load_delay(input logic [CFG_W-1:0] d);
    logic [CMP_W-1:0] dx;
    logic [CMP_W-1:0] mx;
    dx = CMP_W'(d);
    mx = CMP_W'(DELAY_MAX);
    if (dx == '0) dx = CMP_W'(1);
    if (dx > mx) dx = mx;
    return dx[DELAY_BITS-1:0];
  endfunction

endpackage

[rtl/i2c_bit_level_master_unit.sv]
// Top level of the I2C bit-level master: input register, sequencer, result register.
// Depends on i2cbm_pkg, i2cbm_regs and i2cbm_seq.
//
//   port group   direction  handshake            payload
//   in_*         request in  in_valid/in_ready    cmd_valid op tx_byte send_ack sda_in
//   out_*        result out  out_valid/out_ready  scl/sda levels, status, rx_byte
//   cfg_*        APB r/w     psel/penable/pready  four 8-bit delay/timeout registers
//
// One request per clock unless out_ready stalls: each request is one bus tick,
// stepped through the sequencer in the cycle it leaves the input register; its
// result is registered. Throughput: one request per unstalled cycle, one step each.
// Reset (rst_n low, synchronous) gives the bus init state and reloads register defaults.
// A stalled out_ready holds the result register; the input register then fills and
// in_ready drops.
module i2c_bit_level_master_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd_valid,
  input  logic [2:0]                            in_op,
  input  logic [i2cbm_pkg::BYTE_W-1:0]          in_tx_byte,
  input  logic                                  in_send_ack,
  input  logic                                  in_sda_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_scl_level,
  output logic                                  out_sda_level,
  output logic                                  out_sda_driving,
  output logic                                  out_busy_res,
  output logic                                  out_done_res,
  output logic [i2cbm_pkg::BYTE_W-1:0]          out_rx_byte,
  output logic                                  out_ack_missing,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [i2cbm_pkg::PADDR_W-1:0]         cfg_paddr,
  input  logic [i2cbm_pkg::PDATA_W-1:0]         cfg_pwdata,
  output logic [i2cbm_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                  cfg_pready
);
  import i2cbm_pkg::*;

  cfg_t cfg;
  cmd_t in_cmd_r, in_cmd_nxt;
  logic in_v_r,   in_v_nxt;
  res_t res;
  res_t out_res_r, out_res_nxt;
  logic out_v_r,  out_v_nxt;
  logic step_en;
  logic in_acc;

  assign step_en  = in_v_r & (~out_v_r | out_ready);
  assign in_ready = ~in_v_r | step_en;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    in_v_nxt    = in_v_r;
    in_cmd_nxt  = in_cmd_r;
    out_v_nxt   = out_v_r;
    out_res_nxt = out_res_r;
    if (step_en) begin
      in_v_nxt = 1'b0;
    end
    if (in_acc) begin
      in_v_nxt             = 1'b1;
      in_cmd_nxt.cmd_valid = in_cmd_valid;
      in_cmd_nxt.op        = in_op;
      in_cmd_nxt.tx_byte   = in_tx_byte;
      in_cmd_nxt.send_ack  = in_send_ack;
      in_cmd_nxt.sda_in    = in_sda_in;
    end
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (step_en) begin
      out_v_nxt   = 1'b1;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_cmd_r  <= in_cmd_nxt;
    out_res_r <= out_res_nxt;
  end

  i2cbm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  i2cbm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cmd     (in_cmd_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_valid       = out_v_r;
  assign out_scl_level   = out_res_r.scl_level;
  assign out_sda_level   = out_res_r.sda_level;
  assign out_sda_driving = out_res_r.sda_driving;
  assign out_busy_res    = out_res_r.busy_res;
  assign out_done_res    = out_res_r.done_res;
  assign out_rx_byte     = out_res_r.rx_byte;
  assign out_ack_missing = out_res_r.ack_missing;

`ifndef NO_ASSERTIONS
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("sequencer step did not load the result register");

  a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !step_en) |=> (in_v_r && $stable(in_cmd_r)))
    else $error("waiting request lost from the input register");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_res_r.done_res && out_res_r.busy_res))
    else $error("done reported while a sequence is still running");

  a_released_sda: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_res_r.sda_driving || out_res_r.sda_level))
    else $error("SDA level low while the line is released");
`endif

endmodule

[rtl/i2cbm_regs.sv]
// APB-style configuration registers for the I2C bit-level master.
// Depends on i2cbm_pkg for widths, register codes and reset values.
module i2cbm_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [i2cbm_pkg::PDATA_W-1:0]  pwdata,
  output logic [i2cbm_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  output i2cbm_pkg::cfg_t                cfg
);
  import i2cbm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;
  logic [CFG_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LONG_DELAY:  cfg_nxt.long_delay  = pwdata[CFG_W-1:0];
        REG_BIT_DELAY:   cfg_nxt.bit_delay   = pwdata[CFG_W-1:0];
        REG_SHORT_DELAY: cfg_nxt.short_delay = pwdata[CFG_W-1:0];
        REG_ACK_TIMEOUT: cfg_nxt.ack_timeout = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LONG_DELAY:  rd_val = cfg_r.long_delay;
      REG_BIT_DELAY:   rd_val = cfg_r.bit_delay;
      REG_SHORT_DELAY: rd_val = cfg_r.short_delay;
      REG_ACK_TIMEOUT: rd_val = cfg_r.ack_timeout;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = PDATA_W'(rd_val);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_delay  <= LONG_DELAY_RST;
      cfg_r.bit_delay   <= BIT_DELAY_RST;
      cfg_r.short_delay <= SHORT_DELAY_RST;
      cfg_r.ack_timeout <= ACK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/i2cbm_seq.sv]
// Bus sequencer state and one-tick step logic for the I2C bit-level master.
// Depends on i2cbm_pkg for phase and op codes, structs and load_delay.
module i2cbm_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  i2cbm_pkg::cmd_t  cmd,
  input  i2cbm_pkg::cfg_t  cfg,
  output i2cbm_pkg::res_t  res
);
  import i2cbm_pkg::*;

  phase_t                 phase_r,   phase_nxt;
  logic [BIT_IDX_W-1:0]   bit_idx_r, bit_idx_nxt;
  logic [BYTE_W-1:0]      shift_r,   shift_nxt;
  logic [DELAY_BITS-1:0]  dly_r,     dly_nxt;
  logic [CFG_W-1:0]       tmo_r,     tmo_nxt;
  logic                   scl_r,     scl_nxt;
  logic                   sda_r,     sda_nxt;
  logic                   sda_dir_r, sda_dir_nxt;
  logic                   ack_sel_r, ack_sel_nxt;
  logic [BYTE_W-1:0]      rx_r,      rx_nxt;
  logic                   nack_r,    nack_nxt;
  logic                   poll;
  logic                   done;

  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    dly_nxt     = dly_r;
    tmo_nxt     = tmo_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    sda_dir_nxt = sda_dir_r;
    ack_sel_nxt = ack_sel_r;
    rx_nxt      = rx_r;
    nack_nxt    = nack_r;
    poll        = 1'b0;
    done        = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (cmd.cmd_valid) begin
        case (cmd.op)
          OP_START: begin
            sda_dir_nxt = 1'b1;
            sda_nxt     = 1'b1;
            scl_nxt     = 1'b1;
            dly_nxt     = load_delay(cfg.long_delay);
            phase_nxt   = PH_ST1;
          end
          OP_STOP: begin
            sda_dir_nxt = 1'b1;
            scl_nxt     = 1'b0;
            sda_nxt     = 1'b0;
            dly_nxt     = load_delay(cfg.long_delay);
            phase_nxt   = PH_SP1;
          end
          OP_WRITE: begin
            sda_dir_nxt = 1'b1;
            scl_nxt     = 1'b0;
            sda_nxt     = cmd.tx_byte[BYTE_W-1];
            shift_nxt   = {cmd.tx_byte[BYTE_W-2:0], 1'b0};
            bit_idx_nxt = '0;
            dly_nxt     = load_delay(cfg.bit_delay);
            phase_nxt   = PH_WR_LOW;
          end
          OP_WAIT_ACK: begin
            sda_dir_nxt = 1'b0;
            sda_nxt     = 1'b1;
            tmo_nxt     = '0;
            dly_nxt     = load_delay(cfg.short_delay);
            phase_nxt   = PH_WA1;
          end
          OP_READ: begin
            sda_dir_nxt = 1'b0;
            sda_nxt     = 1'b1;
            scl_nxt     = 1'b0;
            shift_nxt   = '0;
            bit_idx_nxt = '0;
            ack_sel_nxt = cmd.send_ack;
            dly_nxt     = load_delay(cfg.bit_delay);
            phase_nxt   = PH_RD_LOW;
          end
          default: ;
        endcase
      end
    end else if (phase_r == PH_WAP) begin
      poll = 1'b1;
    end else if (dly_r > DELAY_BITS'(1)) begin
      dly_nxt = dly_r - DELAY_BITS'(1);
    end else begin
      case (phase_r)
        PH_ST1: begin
          sda_nxt   = 1'b0;
          dly_nxt   = load_delay(cfg.long_delay);
          phase_nxt = PH_ST2;
        end
        PH_ST2: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_SP1: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.long_delay);
          phase_nxt = PH_SP2;
        end
        PH_SP2: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        PH_WA1: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.short_delay);
          phase_nxt = PH_WA2;
        end
        PH_WA2: poll = 1'b1;
        PH_WR_LOW: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.bit_delay);
          phase_nxt = PH_WR_HIGH;
        end
        PH_WR_HIGH: begin
          scl_nxt   = 1'b0;
          dly_nxt   = load_delay(cfg.bit_delay);
          phase_nxt = PH_WR_TAIL;
        end
        PH_WR_TAIL: begin
          if (bit_idx_r == BIT_LAST) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            sda_nxt     = shift_r[BYTE_W-1];
            shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
            dly_nxt     = load_delay(cfg.bit_delay);
            phase_nxt   = PH_WR_LOW;
          end
        end
        PH_RD_LOW: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.short_delay);
          phase_nxt = PH_RD_HIGH;
        end
        PH_RD_HIGH: begin
          shift_nxt = {shift_r[BYTE_W-2:0], cmd.sda_in};
          scl_nxt   = 1'b0;
          dly_nxt   = load_delay(cfg.bit_delay);
          if (bit_idx_r == BIT_LAST) begin
            sda_dir_nxt = 1'b1;
            sda_nxt     = ~ack_sel_r;
            phase_nxt   = PH_AK_LOW;
          end else begin
            bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            phase_nxt   = PH_RD_LOW;
          end
        end
        PH_AK_LOW: begin
          scl_nxt   = 1'b1;
          dly_nxt   = load_delay(cfg.bit_delay);
          phase_nxt = PH_AK_HIGH;
        end
        PH_AK_HIGH: begin
          scl_nxt   = 1'b0;
          rx_nxt    = shift_r;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (poll) begin
      if (!cmd.sda_in) begin
        scl_nxt   = 1'b0;
        nack_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end else if (tmo_r >= cfg.ack_timeout) begin
        nack_nxt    = 1'b1;
        sda_dir_nxt = 1'b1;
        scl_nxt     = 1'b0;
        sda_nxt     = 1'b0;
        dly_nxt     = load_delay(cfg.long_delay);
        phase_nxt   = PH_SP1;
      end else begin
        tmo_nxt   = tmo_r + CFG_W'(1);
        phase_nxt = PH_WAP;
      end
    end
  end

  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_level   = sda_dir_nxt ? sda_nxt : 1'b1;
    res.sda_driving = sda_dir_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_nxt;
    res.ack_missing = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_idx_r <= '0;
      shift_r   <= '0;
      dly_r     <= '0;
      tmo_r     <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      sda_dir_r <= 1'b1;
      ack_sel_r <= 1'b0;
      rx_r      <= '0;
      nack_r    <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      dly_r     <= dly_nxt;
      tmo_r     <= tmo_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      sda_dir_r <= sda_dir_nxt;
      ack_sel_r <= ack_sel_nxt;
      rx_r      <= rx_nxt;
      nack_r    <= nack_nxt;
    end
  end

endmodule
